// File: rtl/core/ltc_pkg.sv
// shared constants and types for the lru tile cache
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int KEY_IN_W   = 64;
    localparam int HANDLE_W   = 32;
    localparam int DIM_W      = 16;
    localparam int STAMP_W    = 64;
    localparam int SLOT_OUT_W = 6;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } dp_ctl_t;

    typedef struct packed {
        logic last_addr;
    } dp_stat_t;

endpackage

// File: rtl/core/ltc_ctrl.sv
// controller state machine for the lru tile cache
`timescale 1ns / 1ps

module ltc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  ltc_pkg::dp_stat_t stat,
    output ltc_pkg::dp_ctl_t  ctl,
    output logic              busy,
    output logic              done
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WRITE = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   needs_scan;

    assign accept     = start && (state_reg == S_IDLE);
    assign needs_scan = (ltc_pkg::cmd_t'(cmd) == ltc_pkg::CMD_GET) ||
                        (ltc_pkg::cmd_t'(cmd) == ltc_pkg::CMD_PUT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_scan ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN:
            begin
                if (stat.last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_WRITE;
            S_WRITE: state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ctl.load   = accept;
    assign ctl.issue  = (state_reg == S_SCAN);
    assign ctl.commit = (state_reg == S_WRITE);
    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_RESP);

    a_resp_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) |-> ($past(state_reg) == S_WRITE))
        else $error("result strobe without a write-back cycle");

    a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> ($past(state_reg) == S_SCAN && $past(stat.last_addr)))
        else $error("drain entered before the last slot was read");

    a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> !ctl.commit)
        else $error("write-back held for more than one cycle");

endmodule

// File: rtl/core/ltc_dpath.sv
// datapath for the lru tile cache: entry memories, scan compare and write-back
`timescale 1ns / 1ps

module ltc_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ltc_pkg::dp_ctl_t                    ctl,
    output ltc_pkg::dp_stat_t                   stat,
    input  logic [1:0]                          cmd,
    input  logic [ltc_pkg::KEY_IN_W-1:0]        key,
    input  logic [ltc_pkg::HANDLE_W-1:0]        tile_handle,
    input  logic [ltc_pkg::DIM_W-1:0]           tile_width,
    input  logic [ltc_pkg::DIM_W-1:0]           tile_height,
    input  logic [ltc_pkg::STAMP_W-1:0]         now,
    output logic                                hit,
    output logic [ltc_pkg::HANDLE_W-1:0]        found_handle,
    output logic [ltc_pkg::SLOT_OUT_W-1:0]      slot_index,
    output logic                                evicted,
    output logic [ltc_pkg::KEY_IN_W-1:0]        evicted_key
);

    // entry memories
    logic [ltc_pkg::KEY_BITS-1:0] key_mem    [ltc_pkg::ENTRIES];
    logic [ltc_pkg::HANDLE_W-1:0] handle_mem [ltc_pkg::ENTRIES];
    logic [ltc_pkg::DIM_W-1:0]    width_mem  [ltc_pkg::ENTRIES];
    logic [ltc_pkg::DIM_W-1:0]    height_mem [ltc_pkg::ENTRIES];
    logic [ltc_pkg::STAMP_W-1:0]  stamp_mem  [ltc_pkg::ENTRIES];

    // latched word
    ltc_pkg::cmd_t                cmd_reg;
    logic [ltc_pkg::KEY_BITS-1:0] key_reg;
    logic [ltc_pkg::HANDLE_W-1:0] handle_reg;
    logic [ltc_pkg::DIM_W-1:0]    width_reg;
    logic [ltc_pkg::DIM_W-1:0]    height_reg;
    logic [ltc_pkg::STAMP_W-1:0]  now_reg;

    // scan pipeline
    logic [ltc_pkg::IDX_W-1:0]    addr_reg;
    logic                         cmp_vld_reg;
    logic [ltc_pkg::IDX_W-1:0]    cmp_idx_reg;
    logic [ltc_pkg::KEY_BITS-1:0] rd_key_reg;
    logic [ltc_pkg::HANDLE_W-1:0] rd_handle_reg;
    logic [ltc_pkg::STAMP_W-1:0]  rd_stamp_reg;

    // scan results
    logic                         match_reg;
    logic [ltc_pkg::IDX_W-1:0]    match_idx_reg;
    logic [ltc_pkg::HANDLE_W-1:0] match_handle_reg;
    logic [ltc_pkg::IDX_W-1:0]    best_idx_reg;
    logic [ltc_pkg::STAMP_W-1:0]  best_stamp_reg;
    logic [ltc_pkg::KEY_BITS-1:0] best_key_reg;

    logic [ltc_pkg::CNT_W-1:0]    fill_count_reg;

    // result registers
    logic                           hit_reg;
    logic [ltc_pkg::HANDLE_W-1:0]   found_handle_reg;
    logic [ltc_pkg::SLOT_OUT_W-1:0] slot_index_reg;
    logic                           evicted_reg;
    logic [ltc_pkg::KEY_IN_W-1:0]   evicted_key_reg;

    logic                         entry_valid;
    logic                         key_match;
    logic                         older;
    logic                         is_get;
    logic                         is_put;
    logic                         not_full;
    logic                         wr_all;
    logic                         wr_stamp;
    logic [ltc_pkg::IDX_W-1:0]    tgt_idx;

    assign entry_valid = ltc_pkg::CNT_W'(cmp_idx_reg) < fill_count_reg;
    assign key_match   = cmp_vld_reg && entry_valid && (rd_key_reg == key_reg);
    assign older       = cmp_vld_reg &&
                         ((cmp_idx_reg == '0) || (rd_stamp_reg < best_stamp_reg));
    assign is_get      = (cmd_reg == ltc_pkg::CMD_GET);
    assign is_put      = (cmd_reg == ltc_pkg::CMD_PUT);
    assign not_full    = fill_count_reg < ltc_pkg::CNT_W'(ltc_pkg::ENTRIES);
    assign stat.last_addr = ctl.issue && (addr_reg == ltc_pkg::IDX_W'(ltc_pkg::ENTRIES - 1));

    always_comb
    begin
        if (match_reg)
        begin
            tgt_idx = match_idx_reg;
        end
        else if (not_full)
        begin
            tgt_idx = fill_count_reg[ltc_pkg::IDX_W-1:0];
        end
        else
        begin
            tgt_idx = best_idx_reg;
        end
    end

    assign wr_all   = ctl.commit && is_put;
    assign wr_stamp = ctl.commit && (is_put || (is_get && match_reg));

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_all)
        begin
            key_mem[tgt_idx]    <= key_reg;
            handle_mem[tgt_idx] <= handle_reg;
            width_mem[tgt_idx]  <= width_reg;
            height_mem[tgt_idx] <= height_reg;
        end
        if (wr_stamp)
        begin
            stamp_mem[tgt_idx] <= now_reg;
        end
        rd_key_reg    <= key_mem[addr_reg];
        rd_handle_reg <= handle_mem[addr_reg];
        rd_stamp_reg  <= stamp_mem[addr_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= ltc_pkg::cmd_t'(cmd);
            key_reg    <= key[ltc_pkg::KEY_BITS-1:0];
            handle_reg <= tile_handle;
            width_reg  <= tile_width;
            height_reg <= tile_height;
            now_reg    <= now;
        end
        cmp_idx_reg <= addr_reg;
        if (key_match && !match_reg)
        begin
            match_idx_reg    <= cmp_idx_reg;
            match_handle_reg <= rd_handle_reg;
        end
        if (older)
        begin
            best_idx_reg   <= cmp_idx_reg;
            best_stamp_reg <= rd_stamp_reg;
            best_key_reg   <= rd_key_reg;
        end
        if (ctl.commit)
        begin
            hit_reg          <= (is_get || is_put) && match_reg;
            found_handle_reg <= (is_get && match_reg) ? match_handle_reg : '0;
            slot_index_reg   <= ((is_get && match_reg) || is_put)
                                ? ltc_pkg::SLOT_OUT_W'(tgt_idx) : '0;
            evicted_reg      <= is_put && !match_reg && !not_full;
            evicted_key_reg  <= (is_put && !match_reg && !not_full)
                                ? ltc_pkg::KEY_IN_W'(best_key_reg) : '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            match_reg      <= 1'b0;
            fill_count_reg <= '0;
        end
        else
        begin
            cmp_vld_reg <= ctl.issue;
            if (ctl.load)
            begin
                addr_reg  <= '0;
                match_reg <= 1'b0;
            end
            else
            begin
                if (ctl.issue)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (key_match)
                begin
                    match_reg <= 1'b1;
                end
            end
            if (ctl.commit)
            begin
                if (cmd_reg == ltc_pkg::CMD_CLEAR)
                begin
                    fill_count_reg <= '0;
                end
                else if (is_put && !match_reg && not_full)
                begin
                    fill_count_reg <= fill_count_reg + 1'b1;
                end
            end
        end
    end

    assign hit          = hit_reg;
    assign found_handle = found_handle_reg;
    assign slot_index   = slot_index_reg;
    assign evicted      = evicted_reg;
    assign evicted_key  = evicted_key_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= ltc_pkg::CNT_W'(ltc_pkg::ENTRIES))
        else $error("fill count beyond the number of entries");

    a_fill_grows_on_new_put: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && is_put && !match_reg && not_full)
        |=> (fill_count_reg == $past(fill_count_reg) + 1'b1))
        else $error("put into a free slot did not advance the fill count");

    a_match_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && match_reg) |-> (ltc_pkg::CNT_W'(match_idx_reg) < fill_count_reg))
        else $error("matched slot lies outside the valid entries");

endmodule

// File: rtl/core/lru_tile_cache.sv
// top level of the lru tile cache
`timescale 1ns / 1ps
//
// fully associative 64-entry tile cache with least-recently-used replacement
// command channel: a word (cmd, key, tile_handle, tile_width, tile_height, now)
// is taken on a rising edge with start high and busy low
// cmd: get, put, clear, or no operation
// result channel: hit, found_handle, slot_index, evicted, evicted_key are valid
// for exactly one cycle while done is high; the receiver cannot stall, so the
// result is simply dropped if not sampled in that cycle
// get and put read every slot once through the key and stamp memories, one slot
// a cycle, then go through the drain state to the write-back state; done follows,
// and busy falls the cycle after done
// clear and no operation skip the scan and go straight to the write-back state
// one word at a time: a new word is taken only while busy is low
// reset empties the cache at once (fill count to zero, no clearing pass) and
// returns to idle; entry contents are not cleared
//
module lru_tile_cache
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [ltc_pkg::KEY_IN_W-1:0]        key,
    input  logic [ltc_pkg::HANDLE_W-1:0]        tile_handle,
    input  logic [ltc_pkg::DIM_W-1:0]           tile_width,
    input  logic [ltc_pkg::DIM_W-1:0]           tile_height,
    input  logic [ltc_pkg::STAMP_W-1:0]         now,
    output logic                                done,
    output logic                                hit,
    output logic [ltc_pkg::HANDLE_W-1:0]        found_handle,
    output logic [ltc_pkg::SLOT_OUT_W-1:0]      slot_index,
    output logic                                evicted,
    output logic [ltc_pkg::KEY_IN_W-1:0]        evicted_key
);

    ltc_pkg::dp_ctl_t  ctl;
    ltc_pkg::dp_stat_t stat;

    ltc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    ltc_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .key          (key),
        .tile_handle  (tile_handle),
        .tile_width   (tile_width),
        .tile_height  (tile_height),
        .now          (now),
        .hit          (hit),
        .found_handle (found_handle),
        .slot_index   (slot_index),
        .evicted      (evicted),
        .evicted_key  (evicted_key)
    );

endmodule
